>>> hdl/csma_pkg.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC package
// Shared types, action codes, register indexes and the FCS function.
// ----------------------------------------------------------------------------
package csma_pkg;

   localparam int CW_WIDTH = 11;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_SENSE      = 4'd1,
      ACT_TRANSMIT   = 4'd2,
      ACT_WAIT_ACK   = 4'd3,
      ACT_SEND_ACK   = 4'd4,
      ACT_DELIVER    = 4'd5,
      ACT_SENT_OK    = 4'd6,
      ACT_DROP_RETRY = 4'd7,
      ACT_DROP_BUSY  = 4'd8,
      ACT_QUEUE_FULL = 4'd9
   } action_type;

   typedef enum logic [1:0] {
      MODE_OFFER    = 2'd0,
      MODE_SENSED   = 2'd1,
      MODE_ACK_WAIT = 2'd2,
      MODE_RX_HDR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_SENSING = 2'd1,
      PH_WAITING = 2'd2
   } phase_type;

   localparam logic [2:0] REG_OWN_MAC   = 3'd0;
   localparam logic [2:0] REG_SLOT      = 3'd1;
   localparam logic [2:0] REG_SIFS      = 3'd2;
   localparam logic [2:0] REG_DIFS      = 3'd3;
   localparam logic [2:0] REG_PHY_DELAY = 3'd4;
   localparam logic [2:0] REG_THRESHOLD = 3'd5;

   localparam logic [15:0] FC_ACK     = 16'h2B00;
   localparam logic [15:0] FC_DATA    = 16'h0008;
   localparam logic [15:0] FC_STATS   = 16'h2100;
   localparam logic [47:0] ADDR_BCAST = 48'hFFFF_FFFF_FFFF;
   localparam logic [23:0] TIME_MAX   = 24'hFF_FFFF;
   localparam logic [15:0] LFSR_SEED  = 16'hACE1;

   typedef struct packed {
      logic [1:0]         mode;
      logic [7:0]         frame_tag;
      logic [47:0]        dest_addr;
      logic [47:0]        src_addr;
      logic [47:0]        third_addr;
      logic [15:0]        seq_nr;
      logic [15:0]        frame_ctl;
      logic [15:0]        duration;
      logic signed [15:0] power_level;
   } req_type;

   typedef struct packed {
      logic [3:0]  action;
      logic [7:0]  tag_out;
      logic [23:0] time_us;
      logic [47:0] ack_dest;
      logic [47:0] ack_third;
      logic [15:0] ack_duration;
      logic [15:0] ack_seq;
      logic [31:0] ack_fcs;
      logic [1:0]  queue_count;
      logic        last;
   } rsp_type;

   typedef struct packed {
      logic [47:0]        own_mac;
      logic [15:0]        slot_us;
      logic [15:0]        sifs_us;
      logic [15:0]        difs_us;
      logic [15:0]        phy_delay_us;
      logic signed [15:0] power_threshold;
   } cfg_type;

   // Reflected CRC-32 over 24 bytes, first byte in the top bits.
   function automatic logic [31:0] crc32_hdr(input logic [191:0] hdr);
      logic [31:0] c;
      c = 32'hFFFF_FFFF;
      for (int b = 0; b < 24; b++) begin
         c = c ^ {24'd0, hdr[191 - 8*b -: 8]};
         for (int i = 0; i < 8; i++) begin
            c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
         end
      end
      return ~c;
   endfunction

endpackage

>>> hdl/csma_ifs.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC channel interfaces
// Request and result channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface csma_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         mode;
   logic [7:0]         frame_tag;
   logic [47:0]        dest_addr;
   logic [47:0]        src_addr;
   logic [47:0]        third_addr;
   logic [15:0]        seq_nr;
   logic [15:0]        frame_ctl;
   logic [15:0]        duration;
   logic signed [15:0] power_level;

   modport source (output valid, mode, frame_tag, dest_addr, src_addr, third_addr, seq_nr,
                   frame_ctl, duration, power_level, input ready);
   modport sink (input valid, mode, frame_tag, dest_addr, src_addr, third_addr, seq_nr,
                 frame_ctl, duration, power_level, output ready);
endinterface

interface csma_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  action;
   logic [7:0]  tag_out;
   logic [23:0] time_us;
   logic [47:0] ack_dest;
   logic [47:0] ack_third;
   logic [15:0] ack_duration;
   logic [15:0] ack_seq;
   logic [31:0] ack_fcs;
   logic [1:0]  queue_count;
   logic        last;

   modport source (output valid, action, tag_out, time_us, ack_dest, ack_third,
                   ack_duration, ack_seq, ack_fcs, queue_count, last, input ready);
   modport sink (input valid, action, tag_out, time_us, ack_dest, ack_third,
                 ack_duration, ack_seq, ack_fcs, queue_count, last, output ready);
endinterface

>>> hdl/csma_csr.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC configuration registers
// Write-only register file for station address, timings and threshold.
// ----------------------------------------------------------------------------
module csma_csr
   import csma_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata,
   output cfg_type     cfg
);
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.own_mac         <= 48'd0;
         cfg_ff.slot_us         <= 16'd9;
         cfg_ff.sifs_us         <= 16'd16;
         cfg_ff.difs_us         <= 16'd34;
         cfg_ff.phy_delay_us    <= 16'd1;
         cfg_ff.power_threshold <= -16'sd17920;
      end else if (csr_we) begin
         case (csr_index)
            REG_OWN_MAC:   cfg_ff.own_mac         <= csr_wdata;
            REG_SLOT:      cfg_ff.slot_us         <= csr_wdata[15:0];
            REG_SIFS:      cfg_ff.sifs_us         <= csr_wdata[15:0];
            REG_DIFS:      cfg_ff.difs_us         <= csr_wdata[15:0];
            REG_PHY_DELAY: cfg_ff.phy_delay_us    <= csr_wdata[15:0];
            REG_THRESHOLD: cfg_ff.power_threshold <= csr_wdata[15:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;
endmodule

>>> hdl/csma_core.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC event core
// Input register, transmit queue, backoff state and result generation.
// ----------------------------------------------------------------------------
module csma_core
   import csma_pkg::*;
#(
   parameter int QUEUE_DEPTH = 3,
   parameter int RETRY_LIMIT = 10,
   parameter int CW_MIN      = 16,
   parameter int CW_MAX      = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  req_type in_item,
   input  cfg_type cfg,
   input  logic    q_empty,
   output logic    push,
   output logic    push_two,
   output rsp_type res0,
   output rsp_type res1
);
   localparam int FW = $clog2(QUEUE_DEPTH + 1);
   localparam int QI = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int NX = (QUEUE_DEPTH > 1) ? 1 : 0;
   localparam logic [FW-1:0] DEPTH_V = FW'(QUEUE_DEPTH);
   localparam logic [3:0] LIMIT_V = 4'(RETRY_LIMIT);
   localparam logic [CW_WIDTH:0] CWMAX_V = (CW_WIDTH+1)'(CW_MAX);
   localparam logic [CW_WIDTH-1:0] CWMIN_V = CW_WIDTH'(CW_MIN);

   logic      in_valid_ff;
   req_type   item_ff;
   logic [7:0]      tags_ff  [QUEUE_DEPTH];
   logic [15:0]     seqs_ff  [QUEUE_DEPTH];
   logic            bcast_ff [QUEUE_DEPTH];
   logic [FW-1:0]   fill_ff, fill_in;
   phase_type       phase_ff, phase_in;
   logic [3:0]      att_ff, att_in, busy_ff, busy_in;
   logic [CW_WIDTH-1:0] cw_ff, cw_in;
   logic [23:0]     st_ff, st_in;
   logic            acked_ff, acked_in;
   logic [15:0]     lfsr_ff, lfsr_in;

   logic fire, do_push, do_pop, is_busy, mine, fin_acked, two;
   logic [3:0]  fin_att, fin_busy;
   logic [23:0] fin_st;
   logic [FW-1:0] fill_dec;
   logic [15:0] lfsr_step;
   logic [CW_WIDTH-2:0] bo;
   logic [25:0] bo_prod;
   logic [CW_WIDTH:0] cw_dbl;
   logic [31:0] fcs;
   rsp_type r0, r1;

   function automatic rsp_type mk(input action_type a, input logic [7:0] t,
                                  input logic [23:0] tm, input logic [FW-1:0] f);
      rsp_type r;
      r = '0;
      r.action      = a;
      r.tag_out     = t;
      r.time_us     = tm;
      r.queue_count = 2'(f);
      return r;
   endfunction

   assign fire     = in_valid_ff && q_empty;
   assign in_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else if (in_ready) in_valid_ff <= in_valid;
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) item_ff <= in_item;
   end

   assign is_busy  = item_ff.power_level >= cfg.power_threshold;
   assign mine     = item_ff.dest_addr == cfg.own_mac;
   assign fill_dec = fill_ff - FW'(1);
   assign lfsr_step = {lfsr_ff[0] ^ lfsr_ff[2] ^ lfsr_ff[3] ^ lfsr_ff[5], lfsr_ff[15:1]};
   assign bo       = lfsr_step[CW_WIDTH-2:0] & 10'(cw_ff - CW_WIDTH'(1));
   assign bo_prod  = 26'(bo) * 26'(cfg.slot_us);
   assign cw_dbl   = {cw_ff, 1'b0};
   assign fcs = crc32_hdr({FC_ACK[7:0], FC_ACK[15:8],
                           item_ff.duration[7:0], item_ff.duration[15:8],
                           item_ff.src_addr, cfg.own_mac, item_ff.third_addr,
                           item_ff.seq_nr[7:0], item_ff.seq_nr[15:8]});

   always_comb begin
      fill_in = fill_ff; phase_in = phase_ff; att_in = att_ff; busy_in = busy_ff;
      cw_in = cw_ff; st_in = st_ff; acked_in = acked_ff; lfsr_in = lfsr_ff;
      do_push = 1'b0; do_pop = 1'b0; two = 1'b0;
      fin_acked = acked_ff; fin_att = att_ff; fin_busy = busy_ff; fin_st = st_ff;
      r0 = mk(ACT_NONE, 8'd0, 24'd0, fill_ff);
      r1 = mk(ACT_NONE, 8'd0, 24'd0, fill_ff);
      case (mode_type'(item_ff.mode))
         MODE_OFFER: begin
            if (fill_ff >= DEPTH_V) begin
               r0 = mk(ACT_QUEUE_FULL, item_ff.frame_tag, 24'd0, fill_ff);
            end else begin
               do_push = 1'b1;
               fill_in = fill_ff + FW'(1);
               if (phase_ff == PH_IDLE) begin
                  att_in = 4'd0; busy_in = 4'd0; acked_in = 1'b0;
                  st_in = {8'd0, cfg.difs_us}; phase_in = PH_SENSING;
                  r0 = mk(ACT_SENSE, (fill_ff == '0) ? item_ff.frame_tag : tags_ff[0],
                          {8'd0, cfg.difs_us}, fill_in);
               end else begin
                  r0 = mk(ACT_NONE, item_ff.frame_tag, 24'd0, fill_in);
               end
            end
         end
         MODE_SENSED, MODE_ACK_WAIT: begin
            if (item_ff.mode == MODE_SENSED && phase_ff == PH_SENSING && fill_ff != '0) begin
               if (!bcast_ff[0]) begin
                  busy_in = (busy_ff == 4'hF) ? busy_ff : busy_ff + 4'd1;
               end
               fin_busy = busy_in;
               if (!acked_ff && !is_busy) begin
                  att_in = att_ff + 4'd1;
                  if (bcast_ff[0]) acked_in = 1'b1;
                  phase_in = PH_WAITING;
                  two = 1'b1;
                  r0 = mk(ACT_TRANSMIT, tags_ff[0], 24'd0, fill_ff);
                  r1 = mk(ACT_WAIT_ACK, tags_ff[0],
                          24'({2'd0, cfg.sifs_us} + {2'd0, cfg.slot_us} +
                              {2'd0, cfg.phy_delay_us}), fill_ff);
               end else begin
                  if (!acked_ff) begin
                     lfsr_in = lfsr_step;
                     cw_in = (cw_dbl >= CWMAX_V) ? CW_WIDTH'(CWMAX_V) : cw_dbl[CW_WIDTH-1:0];
                     st_in = (bo_prod > {2'd0, TIME_MAX}) ? TIME_MAX : bo_prod[23:0];
                     fin_st = st_in;
                  end
                  do_pop = 1'b1;
               end
            end else if (item_ff.mode == MODE_ACK_WAIT && phase_ff == PH_WAITING &&
                         fill_ff != '0) begin
               do_pop = 1'b1;
            end
            // Finish the head frame or sense again after a backoff.
            if (do_pop) begin
               if (fin_acked) begin
                  cw_in = CWMIN_V;
                  r0 = mk(ACT_SENT_OK, tags_ff[0], 24'd0, fill_dec);
               end else if (fin_att >= LIMIT_V) begin
                  r0 = mk(ACT_DROP_RETRY, tags_ff[0], 24'd0, fill_dec);
               end else if (fin_busy >= LIMIT_V) begin
                  r0 = mk(ACT_DROP_BUSY, tags_ff[0], 24'd0, fill_dec);
               end else begin
                  do_pop = 1'b0;
                  phase_in = PH_SENSING;
                  r0 = mk(ACT_SENSE, tags_ff[0], fin_st, fill_ff);
               end
               if (do_pop) begin
                  fill_in = fill_dec;
                  acked_in = 1'b0;
                  if (fill_dec == '0) begin
                     phase_in = PH_IDLE;
                  end else begin
                     att_in = 4'd0; busy_in = 4'd0;
                     st_in = {8'd0, cfg.difs_us}; phase_in = PH_SENSING;
                     two = 1'b1;
                     r1 = mk(ACT_SENSE, tags_ff[NX], {8'd0, cfg.difs_us}, fill_dec);
                  end
               end
            end
         end
         default: begin
            if (mine && (item_ff.frame_ctl == FC_DATA ||
                         item_ff.frame_ctl == FC_STATS)) begin
               r0 = mk(ACT_SEND_ACK, item_ff.frame_tag, 24'd0, fill_ff);
               r0.ack_dest     = item_ff.src_addr;
               r0.ack_third    = item_ff.third_addr;
               r0.ack_duration = item_ff.duration;
               r0.ack_seq      = item_ff.seq_nr;
               r0.ack_fcs      = fcs;
               if (item_ff.frame_ctl == FC_DATA) begin
                  two = 1'b1;
                  r1 = mk(ACT_DELIVER, item_ff.frame_tag, 24'd0, fill_ff);
               end
            end else if (mine && item_ff.frame_ctl == FC_ACK && fill_ff != '0 &&
                         item_ff.seq_nr == seqs_ff[0]) begin
               acked_in = 1'b1;
            end
         end
      endcase
      r0.last = !two;
      r1.last = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff  <= '0;
         phase_ff <= PH_IDLE;
         att_ff   <= 4'd0;
         busy_ff  <= 4'd0;
         cw_ff    <= CWMIN_V;
         st_ff    <= 24'd0;
         acked_ff <= 1'b0;
         lfsr_ff  <= LFSR_SEED;
      end else if (fire) begin
         fill_ff  <= fill_in;
         phase_ff <= phase_in;
         att_ff   <= att_in;
         busy_ff  <= busy_in;
         cw_ff    <= cw_in;
         st_ff    <= st_in;
         acked_ff <= acked_in;
         lfsr_ff  <= lfsr_in;
      end
   end

   // Queue entries: written at the fill position, shifted down on a pop.
   always_ff @(posedge clock) begin
      if (fire && do_push) begin
         tags_ff[fill_ff[QI-1:0]]  <= item_ff.frame_tag;
         seqs_ff[fill_ff[QI-1:0]]  <= item_ff.seq_nr;
         bcast_ff[fill_ff[QI-1:0]] <= item_ff.dest_addr == ADDR_BCAST;
      end else if (fire && do_pop) begin
         for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            tags_ff[i]  <= tags_ff[i+1];
            seqs_ff[i]  <= seqs_ff[i+1];
            bcast_ff[i] <= bcast_ff[i+1];
         end
      end
   end

   assign push     = fire;
   assign push_two = two;
   assign res0     = r0;
   assign res1     = r1;
endmodule

>>> hdl/csma_rspq.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC result buffer
// Holds the one or two results of a request until the sink takes them.
// ----------------------------------------------------------------------------
module csma_rspq
   import csma_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  logic    push_two,
   input  rsp_type res0,
   input  rsp_type res1,
   output logic    empty,
   output logic    out_valid,
   input  logic    out_ready,
   output rsp_type out_data
);
   rsp_type   e0_ff, e1_ff;
   logic [1:0] cnt_ff;

   // The core only pushes into an empty buffer.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else if (push) begin
         cnt_ff <= push_two ? 2'd2 : 2'd1;
      end else if (out_valid && out_ready) begin
         cnt_ff <= cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         e0_ff <= res0;
         e1_ff <= res1;
      end else if (out_valid && out_ready) begin
         e0_ff <= e1_ff;
      end
   end

   assign empty     = cnt_ff == 2'd0;
   assign out_valid = !empty;
   assign out_data  = e0_ff;
endmodule

>>> hdl/csma_ca_mac_controller.sv
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller
// Event-driven CSMA/CA MAC with binary exponential backoff and ack FCS.
// ----------------------------------------------------------------------------
// Each request is one MAC event and gives one or two results. A request is
// registered, evaluated in one pass and its results are placed in a two-entry
// result buffer; the next request is evaluated once that buffer has drained,
// so a stall of the result sink holds back the requests behind it.
module csma_ca_mac_controller
   import csma_pkg::*;
#(
   parameter int QUEUE_DEPTH = 3,
   parameter int RETRY_LIMIT = 10,
   parameter int CW_MIN      = 16,
   parameter int CW_MAX      = 1024
) (
   input  logic        clock,
   input  logic        reset,
   csma_req_if.sink    req_ch,
   csma_rsp_if.source  rsp_ch,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_wdata
);
   cfg_type cfg;
   req_type item;
   rsp_type res0, res1, out_data;
   logic    q_empty, push, push_two;

   assign item.mode          = req_ch.mode;
   assign item.frame_tag     = req_ch.frame_tag;
   assign item.dest_addr     = req_ch.dest_addr;
   assign item.src_addr      = req_ch.src_addr;
   assign item.third_addr    = req_ch.third_addr;
   assign item.seq_nr        = req_ch.seq_nr;
   assign item.frame_ctl     = req_ch.frame_ctl;
   assign item.duration      = req_ch.duration;
   assign item.power_level   = req_ch.power_level;

   csma_csr u_csr (
      .clock, .reset, .csr_we, .csr_index, .csr_wdata, .cfg
   );

   csma_core #(
      .QUEUE_DEPTH(QUEUE_DEPTH), .RETRY_LIMIT(RETRY_LIMIT),
      .CW_MIN(CW_MIN), .CW_MAX(CW_MAX)
   ) u_core (
      .clock, .reset,
      .in_valid(req_ch.valid), .in_ready(req_ch.ready), .in_item(item), .cfg,
      .q_empty, .push, .push_two, .res0, .res1
   );

   csma_rspq u_rspq (
      .clock, .reset, .push, .push_two, .res0, .res1, .empty(q_empty),
      .out_valid(rsp_ch.valid), .out_ready(rsp_ch.ready), .out_data
   );

   assign rsp_ch.action       = out_data.action;
   assign rsp_ch.tag_out      = out_data.tag_out;
   assign rsp_ch.time_us      = out_data.time_us;
   assign rsp_ch.ack_dest     = out_data.ack_dest;
   assign rsp_ch.ack_third    = out_data.ack_third;
   assign rsp_ch.ack_duration = out_data.ack_duration;
   assign rsp_ch.ack_seq      = out_data.ack_seq;
   assign rsp_ch.ack_fcs      = out_data.ack_fcs;
   assign rsp_ch.queue_count  = out_data.queue_count;
   assign rsp_ch.last         = out_data.last;
endmodule

>>> tb/csma_ca_mac_controller_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CSMA/CA MAC controller testbench
// Drives MAC events with random idling and back-pressure, predicts every
// result from a behavioural model of the controller and compares field by
// field in a scoreboard, across several register settings.
// ----------------------------------------------------------------------------
import csma_pkg::*;

class mac_scoreboard;
   // Predictor state and configuration.
   logic [47:0] own_mac;
   logic [15:0] slot_us, sifs_us, difs_us, phy_delay_us;
   logic signed [15:0] power_threshold;
   logic [7:0]  q_tags[3];
   logic [15:0] q_seqs[3];
   bit          q_bcast[3];
   int          q_fill;
   phase_type   phase;
   int          attempts, busy_attempts, cwin;
   logic [23:0] sense_time;
   bit          acked;
   logic [15:0] lfsr;
   rsp_type     pending[$];
   int          errors;
   int          results_seen;

   function void reset_state();
      own_mac = 0; slot_us = 9; sifs_us = 16; difs_us = 34; phy_delay_us = 1;
      power_threshold = -16'sd17920;
      q_fill = 0; phase = PH_IDLE; attempts = 0; busy_attempts = 0; cwin = 16;
      sense_time = 0; acked = 0; lfsr = LFSR_SEED;
      foreach (q_tags[i]) begin
         q_tags[i] = 0; q_seqs[i] = 0; q_bcast[i] = 0;
      end
   endfunction

   function void write_reg(logic [2:0] idx, logic [47:0] val);
      case (idx)
         REG_OWN_MAC:   own_mac = val;
         REG_SLOT:      slot_us = val[15:0];
         REG_SIFS:      sifs_us = val[15:0];
         REG_DIFS:      difs_us = val[15:0];
         REG_PHY_DELAY: phy_delay_us = val[15:0];
         REG_THRESHOLD: power_threshold = val[15:0];
         default: ;
      endcase
   endfunction

   function rsp_type make_result(action_type act, logic [7:0] tag, longint unsigned t);
      rsp_type r;
      r = '0;
      r.action = act;
      r.tag_out = tag;
      r.time_us = (t > 64'hFF_FFFF) ? 24'hFF_FFFF : t[23:0];
      r.queue_count = q_fill[1:0];
      return r;
   endfunction

   function void push_result(action_type act, logic [7:0] tag, longint unsigned t);
      pending.insert(pending.size(), make_result(act, tag, t));
   endfunction

   function logic [31:0] fcs_byte(logic [31:0] c, logic [7:0] b);
      c ^= {24'd0, b};
      for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ 32'hEDB8_8320) : (c >> 1);
      return c;
   endfunction

   function void push_ack(logic [7:0] tag, logic [47:0] src, logic [47:0] third,
                          logic [15:0] dur, logic [15:0] seq);
      logic [31:0] c;
      logic [7:0]  bytes[24];
      rsp_type     r;
      bytes[0] = FC_ACK[7:0]; bytes[1] = FC_ACK[15:8];
      bytes[2] = dur[7:0];    bytes[3] = dur[15:8];
      for (int i = 0; i < 6; i++) begin
         bytes[4 + i]  = src[47 - 8*i -: 8];
         bytes[10 + i] = own_mac[47 - 8*i -: 8];
         bytes[16 + i] = third[47 - 8*i -: 8];
      end
      bytes[22] = seq[7:0]; bytes[23] = seq[15:8];
      c = 32'hFFFF_FFFF;
      foreach (bytes[i]) c = fcs_byte(c, bytes[i]);
      r = make_result(ACT_SEND_ACK, tag, 0);
      r.ack_dest = src; r.ack_third = third; r.ack_duration = dur;
      r.ack_seq = seq; r.ack_fcs = ~c;
      pending.insert(pending.size(), r);
   endfunction

   function void start_head();
      if (q_fill == 0) begin
         phase = PH_IDLE;
         return;
      end
      attempts = 0; busy_attempts = 0; acked = 0;
      sense_time = {8'd0, difs_us};
      phase = PH_SENSING;
      push_result(ACT_SENSE, q_tags[0], sense_time);
   endfunction

   function void finish_or_continue();
      action_type act;
      logic [7:0] tag;
      tag = q_tags[0];
      if (acked) begin
         cwin = 16; act = ACT_SENT_OK;
      end else if (attempts >= 10) begin
         act = ACT_DROP_RETRY;
      end else if (busy_attempts >= 10) begin
         act = ACT_DROP_BUSY;
      end else begin
         phase = PH_SENSING;
         push_result(ACT_SENSE, tag, sense_time);
         return;
      end
      for (int i = 1; i < q_fill; i++) begin
         q_tags[i-1] = q_tags[i]; q_seqs[i-1] = q_seqs[i]; q_bcast[i-1] = q_bcast[i];
      end
      if (q_fill > 0) q_fill--;
      acked = 0;
      push_result(act, tag, 0);
      start_head();
   endfunction

   // Notes an accepted request and queues the results that it causes.
   function void note_request(req_type q);
      int n0;
      rsp_type r;
      bit busy, bc, mine;
      logic [15:0] fb;
      longint unsigned bo, t;
      n0 = pending.size();
      case (mode_type'(q.mode))
         MODE_OFFER: begin
            if (q_fill >= 3) push_result(ACT_QUEUE_FULL, q.frame_tag, 0);
            else begin
               q_tags[q_fill] = q.frame_tag; q_seqs[q_fill] = q.seq_nr;
               q_bcast[q_fill] = (q.dest_addr == ADDR_BCAST);
               q_fill++;
               if (phase == PH_IDLE) start_head();
               else push_result(ACT_NONE, q.frame_tag, 0);
            end
         end
         MODE_SENSED: begin
            if (phase != PH_SENSING || q_fill == 0) push_result(ACT_NONE, 0, 0);
            else begin
               bc = q_bcast[0];
               busy = q.power_level >= power_threshold;
               if (!bc) busy_attempts++;
               if (!acked && !busy) begin
                  attempts++;
                  if (bc) acked = 1;
                  phase = PH_WAITING;
                  push_result(ACT_TRANSMIT, q_tags[0], 0);
                  push_result(ACT_WAIT_ACK, q_tags[0],
                              64'(sifs_us) + 64'(slot_us) + 64'(phy_delay_us));
               end else begin
                  if (!acked) begin
                     fb = (lfsr ^ (lfsr >> 2) ^ (lfsr >> 3) ^ (lfsr >> 5)) & 16'd1;
                     lfsr = (lfsr >> 1) | (fb << 15);
                     bo = 64'(lfsr & 16'(cwin - 1));
                     cwin = (cwin * 2 >= 1024) ? 1024 : cwin * 2;
                     t = bo * 64'(slot_us);
                     sense_time = (t > 64'hFF_FFFF) ? 24'hFF_FFFF : t[23:0];
                  end
                  finish_or_continue();
               end
            end
         end
         MODE_ACK_WAIT: begin
            if (phase != PH_WAITING || q_fill == 0) push_result(ACT_NONE, 0, 0);
            else finish_or_continue();
         end
         default: begin
            mine = (q.dest_addr == own_mac);
            if (mine && q.frame_ctl == FC_DATA) begin
               push_ack(q.frame_tag, q.src_addr, q.third_addr, q.duration, q.seq_nr);
               push_result(ACT_DELIVER, q.frame_tag, 0);
            end else if (mine && q.frame_ctl == FC_STATS) begin
               push_ack(q.frame_tag, q.src_addr, q.third_addr, q.duration, q.seq_nr);
            end else begin
               if (mine && q.frame_ctl == FC_ACK && q_fill > 0 && q.seq_nr == q_seqs[0])
                  acked = 1;
               push_result(ACT_NONE, 0, 0);
            end
         end
      endcase
      r = pending[pending.size() - 1];
      r.last = 1;
      pending[pending.size() - 1] = r;
      if (pending.size() <= n0) $display("internal: no result predicted");
   endfunction

   function void report(string what, logic [63:0] got, logic [63:0] want);
      errors++;
      if (errors <= 40)
         $display("%t mismatch %s: got %0h expected %0h", $realtime, what, got, want);
   endfunction

   function void check_result(rsp_type g);
      rsp_type e;
      results_seen++;
      if (pending.size() == 0) begin
         report("unexpected result", g.action, 0);
         return;
      end
      e = pending[0];
      pending.delete(0);
      if (g.action != e.action) report("action", g.action, e.action);
      if (g.tag_out != e.tag_out) report("tag_out", g.tag_out, e.tag_out);
      if (g.time_us != e.time_us) report("time_us", g.time_us, e.time_us);
      if (g.ack_dest != e.ack_dest) report("ack_dest", g.ack_dest, e.ack_dest);
      if (g.ack_third != e.ack_third) report("ack_third", g.ack_third, e.ack_third);
      if (g.ack_duration != e.ack_duration)
         report("ack_duration", g.ack_duration, e.ack_duration);
      if (g.ack_seq != e.ack_seq) report("ack_seq", g.ack_seq, e.ack_seq);
      if (g.ack_fcs != e.ack_fcs) report("ack_fcs", g.ack_fcs, e.ack_fcs);
      if (g.queue_count != e.queue_count)
         report("queue_count", g.queue_count, e.queue_count);
      if (g.last != e.last) report("last", g.last, e.last);
   endfunction
endclass

module csma_ca_mac_controller_tb;
   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [2:0]  csr_index = REG_OWN_MAC;
   logic [47:0] csr_wdata = '0;

   csma_req_if req_ch();
   csma_rsp_if rsp_ch();

   csma_ca_mac_controller dut (
      .clock(clock), .reset(reset), .req_ch(req_ch.sink), .rsp_ch(rsp_ch.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   mac_scoreboard board;
   bit   idle_off = 0;
   int   hold_cycles = 0;
   int   stall_target = 0;
   int   requests_sent = 0;
   int   setting_count = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      req_ch.valid = 0; req_ch.mode = MODE_OFFER; req_ch.frame_tag = 0;
      req_ch.dest_addr = 0; req_ch.src_addr = 0; req_ch.third_addr = 0;
      req_ch.seq_nr = 0; req_ch.frame_ctl = 0; req_ch.duration = 0;
      req_ch.power_level = 0;
      rsp_ch.ready = 0;
   end

   // Result sink: random stall bursts, plus one long hold-off when asked.
   initial begin
      int gap;
      board = new();
      board.reset_state();
      forever begin
         @(posedge clock);
         if (reset) continue;
         if (rsp_ch.valid && rsp_ch.ready)
            board.check_result('{rsp_ch.action, rsp_ch.tag_out, rsp_ch.time_us,
                                 rsp_ch.ack_dest, rsp_ch.ack_third, rsp_ch.ack_duration,
                                 rsp_ch.ack_seq, rsp_ch.ack_fcs, rsp_ch.queue_count,
                                 rsp_ch.last});
         if (stall_target > 0) begin
            rsp_ch.ready <= 0;
            hold_cycles++;
            if (hold_cycles >= stall_target) begin
               stall_target = 0; hold_cycles = 0;
            end
         end else if (!idle_off && $urandom_range(0, 9) == 0) begin
            // Ready goes low now and stays low until the random stall in gap runs out.
            gap = $urandom_range(0, 10);
            rsp_ch.ready <= 0;
            stall_target = gap;
         end else begin
            rsp_ch.ready <= 1;
         end
      end
   end

   // Valid stays high after an accepted request until the next one or a pause.
   task automatic send_request(req_type q);
      int gap;
      if (!idle_off && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 11);
         req_ch.valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid <= 1;
      req_ch.mode <= q.mode; req_ch.frame_tag <= q.frame_tag;
      req_ch.dest_addr <= q.dest_addr; req_ch.src_addr <= q.src_addr;
      req_ch.third_addr <= q.third_addr; req_ch.seq_nr <= q.seq_nr;
      req_ch.frame_ctl <= q.frame_ctl; req_ch.duration <= q.duration;
      req_ch.power_level <= q.power_level;
      do @(posedge clock); while (!req_ch.ready);
      board.note_request(q);
      requests_sent++;
   endtask

   task automatic drain();
      req_ch.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_csr(logic [2:0] idx, logic [47:0] val);
      @(posedge clock);
      csr_we <= 1; csr_index <= idx; csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      board.write_reg(idx, val);
   endtask

   function automatic logic [47:0] rand48();
      return 48'({$urandom(), $urandom()});
   endfunction

   function automatic req_type make_request(int kind);
      req_type q;
      q.mode = kind[1:0];
      q.frame_tag = 8'($urandom());
      q.dest_addr = ($urandom_range(0, 3) == 0) ? ADDR_BCAST
                  : ($urandom_range(0, 1) ? board.own_mac : rand48());
      q.src_addr = rand48();
      q.third_addr = rand48();
      q.seq_nr = ($urandom_range(0, 1) && board.q_fill > 0) ? board.q_seqs[0]
                                                             : 16'($urandom());
      case ($urandom_range(0, 4))
         0: q.frame_ctl = FC_DATA;
         1: q.frame_ctl = FC_STATS;
         2, 3: q.frame_ctl = FC_ACK;
         default: q.frame_ctl = 16'($urandom());
      endcase
      q.duration = 16'($urandom());
      // Bias sensed power either side of the threshold.
      if ($urandom_range(0, 5) == 0) q.power_level = 16'($urandom());
      else if ($urandom_range(0, 1))
         q.power_level = board.power_threshold - 16'($urandom_range(1, 50));
      else q.power_level = board.power_threshold + 16'($urandom_range(0, 50));
      return q;
   endfunction

   // Mostly the next event that the protocol expects, sometimes noise.
   function automatic req_type next_event();
      int k;
      if ($urandom_range(0, 9) == 0) k = $urandom_range(0, 3);
      else if (board.phase == PH_SENSING) k = MODE_SENSED;
      else if (board.phase == PH_WAITING) k = $urandom_range(0, 2) == 0 ? MODE_RX_HDR
                                                                        : MODE_ACK_WAIT;
      else k = $urandom_range(0, 2) == 0 ? MODE_RX_HDR : MODE_OFFER;
      if ($urandom_range(0, 7) == 0) k = MODE_OFFER;
      return make_request(k);
   endfunction

   task automatic apply_setting(int which);
      setting_count++;
      case (which)
         0: begin
            write_csr(REG_OWN_MAC, 48'h0); write_csr(REG_SLOT, 48'h0);
            write_csr(REG_SIFS, 48'h0); write_csr(REG_DIFS, 48'h0);
            write_csr(REG_PHY_DELAY, 48'h0); write_csr(REG_THRESHOLD, 48'h8000);
         end
         1: begin
            write_csr(REG_OWN_MAC, 48'hFFFF_FFFF_FFFE); write_csr(REG_SLOT, 48'hFFFF);
            write_csr(REG_SIFS, 48'hFFFF); write_csr(REG_DIFS, 48'hFFFF);
            write_csr(REG_PHY_DELAY, 48'hFFFF); write_csr(REG_THRESHOLD, 48'h7FFF);
         end
         default: begin
            write_csr(REG_OWN_MAC, rand48()); write_csr(REG_SLOT, 48'($urandom()));
            write_csr(REG_SIFS, 48'($urandom())); write_csr(REG_DIFS, 48'($urandom()));
            write_csr(REG_PHY_DELAY, 48'($urandom()));
            write_csr(REG_THRESHOLD, 48'($urandom()));
         end
      endcase
   endtask

   initial begin
      req_type q;
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: offers to fill the queue and overflow, sensed and ack-wait out of phase,
      // busy and idle sensing, a broadcast frame, data, metrics and ack headers.
      q = make_request(MODE_SENSED); send_request(q);
      q = make_request(MODE_ACK_WAIT); send_request(q);
      for (int i = 0; i < 4; i++) begin
         q = make_request(MODE_OFFER);
         q.dest_addr = (i == 1) ? ADDR_BCAST : 48'h0;
         q.frame_tag = (i == 0) ? 8'h00 : 8'hFF;
         q.seq_nr = (i == 0) ? 16'hFFFF : 16'h0;
         send_request(q);
      end
      q = make_request(MODE_SENSED); q.power_level = 16'sh7FFF; send_request(q);
      q = make_request(MODE_SENSED); q.power_level = 16'sh8000; send_request(q);
      q = make_request(MODE_RX_HDR); q.dest_addr = board.own_mac;
      q.frame_ctl = FC_ACK; q.seq_nr = board.q_seqs[0]; send_request(q);
      q = make_request(MODE_ACK_WAIT); send_request(q);
      q = make_request(MODE_SENSED); q.power_level = 16'sh8000; send_request(q);
      q = make_request(MODE_ACK_WAIT); send_request(q);
      q = make_request(MODE_RX_HDR); q.dest_addr = board.own_mac;
      q.frame_ctl = FC_DATA; q.src_addr = 48'hFFFF_FFFF_FFFF; q.third_addr = 0;
      q.duration = 16'hFFFF; send_request(q);
      q = make_request(MODE_RX_HDR); q.dest_addr = board.own_mac;
      q.frame_ctl = FC_STATS; q.src_addr = 0; q.third_addr = 48'hFFFF_FFFF_FFFF;
      q.duration = 0; send_request(q);
      q = make_request(MODE_RX_HDR); q.dest_addr = ADDR_BCAST;
      q.frame_ctl = FC_DATA; send_request(q);
      // Busy sensing ten times in a row runs out the busy budget.
      for (int i = 0; i < 11; i++) begin
         q = make_request(MODE_SENSED); q.power_level = 16'sh7FFF; send_request(q);
      end
      drain();

      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         apply_setting(phase_no < 2 ? phase_no : 2);
         if (phase_no == 5) idle_off = 1;
         for (int i = 0; i < 300; i++) begin
            if (phase_no == 2 && i == 50) stall_target = 200;
            q = next_event();
            send_request(q);
         end
         // Sender pauses until every expected result has come.
         drain();
      end

      drain();
      $display("Covered %0d requests and %0d results over %0d register settings.",
               requests_sent, board.results_seen, setting_count);
      if (board.errors == 0 && board.pending.size() == 0)
         $display("csma_ca_mac_controller_tb: clean");
      else
         $display("csma_ca_mac_controller_tb: errors");
      $finish;
   end

   initial begin
      #4000000;
      $display("Timed out with %0d results outstanding.", board.pending.size());
      $display("csma_ca_mac_controller_tb: errors");
      $finish;
   end
endmodule

>>> sim.f
hdl/csma_pkg.sv
hdl/csma_ifs.sv
hdl/csma_csr.sv
hdl/csma_core.sv
hdl/csma_rspq.sv
hdl/csma_ca_mac_controller.sv
tb/csma_ca_mac_controller_tb.sv
